// ----- src/vld_pkg.sv -----
// Shared types and constants for the vector L1/L2 distance unit.
// No dependencies; imported by every module of the block.
package vld_pkg;

  localparam int VAL_W      = 16;  // element width
  localparam int TERM_W     = 2 * VAL_W;  // squared difference
  localparam int SUM_W      = 47;  // running sum, saturating
  localparam int DIST_W     = 38;  // result, 8 fraction bits
  localparam int FRAC_W     = 8;
  localparam int ROOT_W     = 32;  // integer root of (sum << 16)
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 1;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int ITER_W     = $clog2(ROOT_STEPS);

  typedef enum logic [1:0] {
    S_RUN,
    S_LOAD,
    S_ROOT,
    S_PUBLISH
  } vld_state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // input transaction this cycle
    logic load;     // last term is in the term stage: close the sum
    logic step;     // one square-root iteration
    logic publish;  // write the result register
  } vld_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mode_l1;   // mode of the term currently staged
    logic out_free;  // result register can take a new value
  } vld_status_t;

endpackage

// ----- src/vld_ctrl.sv -----
// Controller of the distance unit: state machine and square-root step counter.
// Depends on vld_pkg.
module vld_ctrl
  import vld_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        last_element,
  output logic        in_ready,
  input  vld_status_t status,
  output vld_cmd_t    cmd
);

  vld_state_t         state, state_next;
  logic [ITER_W-1:0]  iter, iter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      iter  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

  always_comb begin
    state_next = state;
    iter_next  = iter;
    case (state)
      S_RUN: begin
        if (in_valid && last_element) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        iter_next  = '0;
        state_next = status.mode_l1 ? S_PUBLISH : S_ROOT;
      end
      S_ROOT: begin
        iter_next = iter + 1'b1;
        if (iter == ITER_W'(ROOT_STEPS - 1)) begin
          state_next = S_PUBLISH;
        end
      end
      S_PUBLISH: begin
        if (status.out_free) begin
          state_next = S_RUN;
        end
      end
      default: state_next = S_RUN;
    endcase
  end

  always_comb begin
    cmd         = '0;
    in_ready    = 1'b0;
    case (state)
      S_RUN: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_LOAD:    cmd.load    = 1'b1;
      S_ROOT:    cmd.step    = 1'b1;
      S_PUBLISH: cmd.publish = status.out_free;
      default:   cmd         = '0;
    endcase
  end

endmodule

// ----- src/vld_datapath.sv -----
// Datapath of the distance unit: term stage, saturating accumulator,
// restoring square root (one root bit per step) and result register.
// Depends on vld_pkg.
module vld_datapath
  import vld_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_data,
  input  logic [VAL_W-1:0]  value_a,
  input  logic [VAL_W-1:0]  value_b,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [DIST_W-1:0] distance,
  input  vld_cmd_t          cmd,
  output vld_status_t       status
);

  logic               l1_mode;
  logic               term_valid;
  logic               term_mode;
  logic [TERM_W-1:0]  term;
  logic [SUM_W-1:0]   running_sum;
  logic [SUM_W-1:0]   final_sum;
  logic               final_mode;
  logic [RAD_W-1:0]   radicand;
  logic [REM_W-1:0]   rem;
  logic [ROOT_W-1:0]  root;

  logic [VAL_W-1:0]   diff;
  logic [TERM_W-1:0]  term_next;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   sum_next;
  logic [REM_W+1:0]   rem_sh;
  logic [REM_W+1:0]   trial;
  logic [REM_W+1:0]   rem_sub;
  logic [DIST_W-1:0]  l1_dist;
  logic [DIST_W-1:0]  result;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_mode <= 1'b0;
    end else if (cfg_valid) begin
      l1_mode <= cfg_data;
    end
  end

  // stage 1: difference and term
  always_comb begin
    diff      = (value_a >= value_b) ? (value_a - value_b) : (value_b - value_a);
    term_next = l1_mode ? TERM_W'(diff) : (diff * diff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_valid <= 1'b0;
    end else begin
      term_valid <= cmd.accept;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      term      <= term_next;
      term_mode <= l1_mode;
    end
  end

  // stage 2: saturating accumulate
  always_comb begin
    sum_add  = {1'b0, running_sum} + (SUM_W + 1)'(term);
    sum_next = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (cmd.load) begin
      running_sum <= '0;
    end else if (term_valid) begin
      running_sum <= sum_next;
    end
  end

  // square root of (sum << 16), two radicand bits per step
  always_comb begin
    rem_sh  = {rem, radicand[RAD_W-1 -: 2]};
    trial   = {1'b0, root, 2'b01};
    rem_sub = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      final_sum  <= sum_next;
      final_mode <= term_mode;
      radicand   <= {1'b0, sum_next, 16'b0};
      rem        <= '0;
      root       <= '0;
    end else if (cmd.step) begin
      radicand <= {radicand[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sub[REM_W-1:0];
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[REM_W-1:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // result conversion and output register
  always_comb begin
    if (final_sum[SUM_W-1:DIST_W-FRAC_W] != '0) begin
      l1_dist = {DIST_W{1'b1}};
    end else begin
      l1_dist = {final_sum[DIST_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
    end
    result = final_mode ? l1_dist : DIST_W'(root);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      distance <= result;
    end
  end

  assign status.mode_l1  = term_mode;
  assign status.out_free = !out_valid || out_ready;

endmodule

// ----- src/vector_l1_l2_distance_unit.sv -----
// Top level of the vector L1/L2 distance unit.
// Depends on vld_pkg, vld_ctrl and vld_datapath.
//
// One input transaction carries one column of two vectors (value_a,
// value_b) and a last_element flag. Columns are taken one per clock;
// each one adds |a-b| (l1_mode = 1) or (a-b)^2 (l1_mode = 0) to a 47-bit
// sum that saturates rather than wraps. The column flagged last closes the
// vector pair: the block then stops taking columns until the result is
// published. In L1 mode the result is sum << 8, saturated to 38 bits; in
// L2 mode a restoring square root produces one bit of floor(sqrt(sum) * 256)
// per cycle. The result is written into an output register and one
// distance transaction is offered; the next vector pair can start as soon
// as the register is handed over, even while the result still waits. The
// sum is cleared after every result. l1_mode is written through the cfg
// channel (always ready) and should only change between pairs; each column
// uses the mode in force when it is taken.
module vector_l1_l2_distance_unit
  import vld_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  // column input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [VAL_W-1:0]  value_a,
  input  logic [VAL_W-1:0]  value_b,
  input  logic              last_element,
  // distance output channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIST_W-1:0] distance
);

  vld_cmd_t    cmd;
  vld_status_t status;

  // config register has no side effects to wait on
  assign cfg_ready = 1'b1;

  vld_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .last_element (last_element),
    .in_ready     (in_ready),
    .status       (status),
    .cmd          (cmd)
  );

  vld_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .value_a   (value_a),
    .value_b   (value_b),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .distance  (distance),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ----- src/vld_checker.sv -----
// Port-level checks for the distance unit, bound to the top level.
// Depends on vld_pkg and vector_l1_l2_distance_unit.
module vld_checker
  import vld_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic              cfg_data,
  input logic              in_valid,
  input logic              in_ready,
  input logic [VAL_W-1:0]  value_a,
  input logic [VAL_W-1:0]  value_b,
  input logic              last_element,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DIST_W-1:0] distance
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance))
    else $error("distance changed while stalled");

  // closing a pair blocks the next column through the load state and the state after it
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_element |=> !in_ready ##1 !in_ready)
    else $error("column taken while a result is in progress");

  // a result appears only out of the busy phase
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result offered without a closed vector pair");

  // config channel never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind vector_l1_l2_distance_unit vld_checker u_vld_checker (.*);

// ----- tb/sv/vld_distance_checker.sv -----
// Scoreboard for the vector L1/L2 distance unit. It watches the cfg, column
// and distance channels, predicts every distance and compares it.
// Depends on vld_pkg.
module vld_distance_checker
  import vld_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [VAL_W-1:0]  value_a,
  input  logic [VAL_W-1:0]  value_b,
  input  logic              last_element,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [DIST_W-1:0] distance,
  output int                mismatches,
  output int                pending
);

  localparam logic [SUM_W-1:0]  SUM_SAT  = {SUM_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

  logic              mode_l1;
  logic [SUM_W-1:0]  pair_sum;
  logic [DIST_W-1:0] want_dist;
  logic [DIST_W-1:0] dist_q[$];
  int                fail_count = 0;

  assign mismatches = fail_count;

  function automatic logic [TERM_W-1:0] column_term(input logic l1,
                                                    input logic [VAL_W-1:0] a,
                                                    input logic [VAL_W-1:0] b);
    logic [TERM_W-1:0] diff;
    diff = (a >= b) ? a - b : b - a;
    return l1 ? diff : diff * diff;
  endfunction

  function automatic logic [SUM_W-1:0] add_saturating(input logic [SUM_W-1:0] s,
                                                      input logic [TERM_W-1:0] t);
    logic [SUM_W:0] total;
    total = s + t;
    return total[SUM_W] ? SUM_SAT : total[SUM_W-1:0];
  endfunction

  // bit-by-bit root: keep each bit whose square still fits under the radicand
  function automatic logic [ROOT_W-1:0] int_sqrt(input logic [RAD_W-1:0] rad);
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-1:0] trial;
    logic [RAD_W-1:0]  sq;
    root = '0;
    for (int i = ROOT_W - 1; i >= 0; i--) begin
      trial    = root;
      trial[i] = 1'b1;
      sq       = trial * trial;
      if (sq <= rad) root = trial;
    end
    return root;
  endfunction

  function automatic logic [DIST_W-1:0] pair_distance(input logic l1,
                                                      input logic [SUM_W-1:0] s);
    logic [RAD_W-1:0] rad;
    if (l1) begin
      if (s[SUM_W-1:DIST_W-FRAC_W] != '0) return DIST_SAT;
      return {s[DIST_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
    end
    // sqrt(sum) * 2^8 == sqrt(sum * 2^16)
    rad = {1'b0, s, {(2 * FRAC_W){1'b0}}};
    return DIST_W'(int_sqrt(rad));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mode_l1  = 1'b0;
      pair_sum = '0;
      dist_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) mode_l1 = cfg_data;
      if (in_valid && in_ready) begin
        pair_sum = add_saturating(pair_sum, column_term(mode_l1, value_a, value_b));
        if (last_element) begin
          dist_q.insert(dist_q.size(), pair_distance(mode_l1, pair_sum));
          pair_sum = '0;
        end
      end
      if (out_valid && out_ready) begin
        if (dist_q.size() == 0) begin
          $error("distance: expected none, actual %0d", distance);
          fail_count++;
        end else begin
          want_dist = dist_q.pop_front();
          if (distance !== want_dist) begin
            $error("distance: expected %0d, actual %0d", want_dist, distance);
            fail_count++;
          end
        end
      end
    end
    pending <= dist_q.size();
  end

endmodule

// ----- tb/sv/tb_vector_l1_l2_distance_unit.sv -----
// Testbench top for the vector L1/L2 distance unit: drives columns, mode
// writes and output backpressure, and gives the verdict.
// Depends on vld_pkg, vector_l1_l2_distance_unit and vld_distance_checker.
module tb_vector_l1_l2_distance_unit
  import vld_pkg::*;
;

  localparam int RANDOM_COLUMNS   = 550;
  localparam int SETTLE_CYCLES    = 40;     // covers the L2 close
  localparam int IDLE_LIMIT       = 2000;   // cycles with no transaction at all
  localparam int LONG_RUN_COLUMNS = 64;     // back-to-back full-scale pair

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [VAL_W-1:0]  value_a;
  logic [VAL_W-1:0]  value_b;
  logic              last_element;
  logic              out_valid;
  logic              out_ready;
  logic [DIST_W-1:0] distance;

  int   mismatches;
  int   pending;
  int   idle_cycles = 0;
  int   columns_sent = 0;
  logic mode_now = 1'b0;  // mode last written by the stimulus

  vector_l1_l2_distance_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value_a      (value_a),
    .value_b      (value_b),
    .last_element (last_element),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .distance     (distance)
  );

  vld_distance_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value_a      (value_a),
    .value_b      (value_b),
    .last_element (last_element),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .distance     (distance),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length shared by sender and receiver: mostly none or short,
  // now and then long enough to straddle a whole square-root pass.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Elements lean on the corners (absent entry, full scale, tiny values)
  // but are mostly uniform so every bit toggles.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return VAL_W'($urandom_range(0, 15));
      default: return VAL_W'($urandom());
    endcase
  endfunction

  // One column transaction. Valid rises with the payload and holds until
  // accepted; the optional gap afterwards drops valid.
  task automatic send_column(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                             input logic last, input bit gaps);
    int n;
    in_valid     <= 1'b1;
    value_a      <= a;
    value_b      <= b;
    last_element <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gaps) begin
      n = pause_len();
      if (n > 0) begin
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  endtask

  // Hold off the sender until every predicted distance has come out, then
  // let the block finish whatever close it may still be running.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mode write; only called after reset or right after drain(), so the block is idle.
  task automatic write_mode(input logic l1);
    cfg_valid <= 1'b1;
    cfg_data  <= l1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_now = l1;
  endtask

  // Back-to-back run of identical columns closed by a last column.
  task automatic send_run(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                          input int count);
    for (int i = 0; i < count; i++) send_column(a, b, i == count - 1, 1'b0);
  endtask

  // Random vector pair. A quarter of the pairs stream with no gaps; about
  // one in ten flips the mode partway through the pair.
  task automatic send_pair(input int len);
    bit gaps;
    int flip_at;
    gaps    = ($urandom_range(0, 3) != 0);
    flip_at = 0;
    if (len > 1 && $urandom_range(0, 9) == 0) flip_at = $urandom_range(1, len - 1);
    for (int i = 0; i < len; i++) begin
      if (flip_at > 0 && i == flip_at) begin
        drain();
        write_mode(!mode_now);
      end
      send_column(pick_value(), pick_value(), i == len - 1, gaps);
    end
    columns_sent += len;
  endtask

  // Result backpressure: bursts of ready broken by stalls of random length,
  // often with no stall at all.
  initial begin : ready_gen
    int hold;
    out_ready = 1'b0;
    forever begin
      hold = $urandom_range(1, 40);
      repeat (hold) begin
        @(posedge clk);
        out_ready <= 1'b1;
      end
      hold = pause_len();
      repeat (hold) begin
        @(posedge clk);
        out_ready <= 1'b0;
      end
    end
  end

  // Watchdog: a run that stops moving transactions is a failure.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    int len;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b0;
    in_valid     = 1'b0;
    value_a      = '0;
    value_b      = '0;
    last_element = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // --- directed: Euclidean mode (written although it is the reset value)
    write_mode(1'b0);
    send_column('0, '0, 1'b1, 1'b1);              // zero vector
    send_column('1, '0, 1'b1, 1'b1);              // largest a - b
    send_column('0, '1, 1'b1, 1'b1);              // largest b - a
    send_column(16'h3039, 16'h3039, 1'b1, 1'b1);  // equal elements
    send_column(16'd3, '0, 1'b0, 1'b1);           // 3-4-5 triangle, exact root
    send_column('0, 16'd4, 1'b0, 1'b1);
    send_column('0, '0, 1'b1, 1'b1);
    send_column(16'd1, '0, 1'b0, 1'b1);           // sqrt(2), root truncates
    send_column('0, 16'd1, 1'b1, 1'b1);
    send_column(16'hAAAA, 16'h5555, 1'b1, 1'b1);

    // mode change inside a pair: first term squared, second absolute
    send_column(16'd100, '0, 1'b0, 1'b1);
    drain();
    write_mode(1'b1);
    send_column('0, 16'd50, 1'b1, 1'b1);

    // --- directed: L1 mode
    send_column('1, '0, 1'b1, 1'b1);
    send_column('0, '1, 1'b1, 1'b1);
    send_column(16'd5, 16'd5, 1'b1, 1'b1);
    send_column(16'h5555, 16'hAAAA, 1'b1, 1'b1);

    // and back: absolute term first, L2 close
    send_column(16'd7, 16'd2, 1'b0, 1'b1);
    drain();
    write_mode(1'b0);
    send_column('0, 16'd3, 1'b1, 1'b1);

    // --- long back-to-back pairs of full-scale columns in both modes
    drain();
    send_run('1, '0, LONG_RUN_COLUMNS);
    drain();
    write_mode(1'b1);
    send_run('0, '1, LONG_RUN_COLUMNS);
    drain();
    write_mode(1'b0);

    // --- random pairs, mostly short, with mode writes between pairs
    while (columns_sent < RANDOM_COLUMNS) begin
      if ($urandom_range(0, 7) == 0) begin
        drain();
        write_mode($urandom_range(0, 1) == 1);
      end
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      send_pair(len);
    end

    // wait out every result plus a quiet tail for strays
    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
